>>> rtl/core/ppqs_pkg.sv
// Package for the priority promoting queue with stack.
// Holds entry, command and result types, operation and status codes, and default sizes.
// No dependencies.
package ppqs_pkg;
	localparam int DefDepth = 16;
	localparam logic [7:0] DefPriorityAge = 8'd70;

	typedef struct packed {
		logic [31:0] tag;
		logic [7:0]  age;
		logic [15:0] ticket;
	} entry_t;

	typedef enum logic [2:0] {
		OP_ENQ = 3'd0, OP_DEQ = 3'd1, OP_PROMOTE = 3'd2, OP_Q2S = 3'd3, OP_S2Q = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_Q_EMPTY = 3'd1, ST_Q_FULL = 3'd2, ST_NO_PRIO = 3'd3,
		ST_S_EMPTY = 3'd4, ST_PARTIAL = 3'd5
	} status_t;

	typedef enum logic [1:0] {FSM_IDLE, FSM_PROMOTE, FSM_XFER, FSM_DONE} fsm_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] patient_tag;
		logic [7:0]  age;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] entry_tag;
		logic [7:0]  entry_age;
		logic [15:0] entry_ticket;
		logic [4:0]  queue_count;
		logic [4:0]  stack_count;
	} rsp_t;

	// Per-cell control, common to every cell of a row.
	typedef struct packed {
		logic shift_in;  // cells up to lim shift toward tail; cell 0 takes the row input
		logic shift_out; // cells from lim on shift toward head
		logic load;      // cell lim takes the row input
	} cell_ctl_t;
endpackage

>>> rtl/core/ppqs_if.sv
// Valid/ready channel interface for the queue block.
// Takes its payload type as a parameter; it does not import ppqs_pkg itself.
interface ppqs_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ppqs_cell.sv
// One storage cell of a shifting row of entries.
// Depends on ppqs_pkg.
module ppqs_cell (
	input  logic                clk,
	input  ppqs_pkg::cell_ctl_t ctl,
	input  logic                sel,
	input  ppqs_pkg::entry_t    ext,
	input  ppqs_pkg::entry_t    from_prev,
	input  ppqs_pkg::entry_t    from_next,
	output ppqs_pkg::entry_t    value
);
	import ppqs_pkg::*;
	entry_t value_q;
	always_ff @(posedge clk) begin
		if (sel && ctl.shift_in) begin
			value_q <= from_prev;
		end else if (sel && ctl.shift_out) begin
			value_q <= from_next;
		end else if (sel && ctl.load) begin
			value_q <= ext;
		end
	end
	assign value = value_q;
endmodule

>>> rtl/core/ppqs_row.sv
// A row of cells; cell 0 is the head. Shift-in moves cells [0..lim] toward the
// tail with head_in at cell 0; shift-out moves cells [lim..] toward the head; load writes cell lim.
// Depends on ppqs_pkg and ppqs_cell.
module ppqs_row #(parameter int Depth = ppqs_pkg::DefDepth) (
	input  logic                     clk,
	input  ppqs_pkg::cell_ctl_t      ctl,
	input  logic [$clog2(Depth)-1:0] lim,
	input  ppqs_pkg::entry_t         head_in,
	output ppqs_pkg::entry_t         cells [Depth]
);
	import ppqs_pkg::*;
	for (genvar i = 0; i < Depth; i++) begin : g_cell
		logic sel;
		entry_t prev_e, next_e;
		assign sel = ctl.shift_in ? (i <= int'(lim)) :
			ctl.shift_out ? (i >= int'(lim)) : (i == int'(lim));
		if (i == 0) begin : g_h
			assign prev_e = head_in;
		end else begin : g_b
			assign prev_e = cells[i-1];
		end
		if (i == Depth-1) begin : g_t
			assign next_e = cells[i];
		end else begin : g_m
			assign next_e = cells[i+1];
		end
		ppqs_cell u_cell (.clk(clk), .ctl(ctl), .sel(sel), .ext(head_in), .from_prev(prev_e),
			.from_next(next_e), .value(cells[i]));
	end
endmodule

>>> rtl/core/priority_promoting_queue_with_stack.sv
// Top level of the priority promoting queue with stack.
// Depends on ppqs_pkg, ppqs_if and ppqs_row.
//
// Channels: cmd (sink) takes operation, patient_tag and age; rsp (source)
// returns one result per command: status, entry fields and both fills.
// cfg (sink) writes priority_age; write it only while the block is idle.
// Both stores are rows of cells, the queue with its head in cell 0 and the
// stack with its top in cell 0.
// The result is valid the cycle after acceptance for enqueue, dequeue, the
// unused codes, promote on an empty queue and stack-to-queue on an empty
// stack.
// Promote scans one queued entry per cycle from the head and moves the first
// aged entry to the head in the cycle that finds it.
// Transfers move one entry per cycle until the source store is empty or the
// destination store is full, and then stop.
// The block takes one command at a time; cmd ready is low from acceptance
// until the result transaction is taken, so a stalled receiver stalls cmd and
// the result is held unchanged meanwhile.
// Reset empties both stores, sets the next ticket to 1 and priority_age to 70.
module priority_promoting_queue_with_stack #(
	parameter int Depth = ppqs_pkg::DefDepth
) (
	input logic clk,
	input logic arst_n,
	ppqs_if.sink   cmd,
	ppqs_if.sink   cfg,
	ppqs_if.source rsp
);
	import ppqs_pkg::*;
	localparam int Aw = $clog2(Depth);
	localparam int Cw = $clog2(Depth + 1);

	fsm_t state_q, state_d;
	logic [7:0] prio_q;
	logic [15:0] ticket_q;
	logic [Cw-1:0] qfill_q, sfill_q;
	logic [Aw-1:0] scan_q;
	logic [2:0] op_q;
	status_t status_q;
	entry_t shown_q;
	entry_t qcells [Depth];
	entry_t scells [Depth];
	cell_ctl_t qctl, sctl;
	logic [Aw-1:0] qlim, slim;
	entry_t qin, sin;
	entry_t scan_e;
	entry_t new_e;
	logic prio_hit, scan_last;
	cmd_t c;
	rsp_t rsp_d;

	assign c = cmd.data;
	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == FSM_IDLE);
	assign rsp.valid = (state_q == FSM_DONE);

	ppqs_row #(.Depth(Depth)) u_q (.clk(clk), .ctl(qctl), .lim(qlim), .head_in(qin),
		.cells(qcells));
	ppqs_row #(.Depth(Depth)) u_s (.clk(clk), .ctl(sctl), .lim(slim), .head_in(sin),
		.cells(scells));

	logic qfull, qempty, sfull, sempty;
	assign qfull = (qfill_q == Cw'(Depth));
	assign qempty = (qfill_q == '0);
	assign sfull = (sfill_q == Cw'(Depth));
	assign sempty = (sfill_q == '0);

	assign scan_e = qcells[scan_q];
	assign prio_hit = (scan_e.age >= prio_q);
	assign scan_last = ((Cw'(scan_q) + Cw'(1)) == qfill_q);
	assign new_e = '{c.patient_tag, c.age, ticket_q};

	always_comb begin
		state_d = state_q;
		qctl = '0; sctl = '0;
		qlim = '0; slim = '0;
		qin = qcells[0]; sin = qcells[0];
		case (state_q)
			FSM_IDLE: begin
				if (cmd.valid) begin
					state_d = FSM_DONE;
					case (c.operation)
						OP_ENQ: begin
							if (!qfull) begin
								qctl.load = 1'b1;
								qlim = Aw'(qfill_q);
								qin = new_e;
							end
						end
						OP_DEQ: begin
							if (!qempty) qctl.shift_out = 1'b1;
						end
						OP_PROMOTE: begin
							if (!qempty) state_d = FSM_PROMOTE;
						end
						OP_Q2S: state_d = FSM_XFER;
						OP_S2Q: begin
							if (!sempty) state_d = FSM_XFER;
						end
						default: ;
					endcase
				end
			end
			FSM_PROMOTE: begin
				if (prio_hit) begin
					// Entries ahead of the hit move back one cell; the hit lands at the head.
					qctl.shift_in = 1'b1;
					qlim = scan_q;
					qin = scan_e;
					state_d = FSM_DONE;
				end else if (scan_last) begin
					state_d = FSM_DONE;
				end
			end
			FSM_XFER: begin
				if (op_q == OP_Q2S) begin
					if (!qempty && !sfull) begin
						sctl.shift_in = 1'b1;
						slim = Aw'(Depth - 1);
						sin = qcells[0];
						qctl.shift_out = 1'b1;
					end else begin
						state_d = FSM_DONE;
					end
				end else begin
					if (!sempty && !qfull) begin
						qctl.load = 1'b1;
						qlim = Aw'(qfill_q);
						qin = scells[0];
						sctl.shift_out = 1'b1;
					end else begin
						state_d = FSM_DONE;
					end
				end
			end
			FSM_DONE: begin
				if (rsp.ready) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= DefPriorityAge;
			ticket_q <= 16'd1;
			qfill_q <= '0;
			sfill_q <= '0;
			scan_q <= '0;
			op_q <= '0;
			status_q <= ST_OK;
			shown_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) prio_q <= cfg.data;
			case (state_q)
				FSM_IDLE: begin
					if (cmd.valid) begin
						op_q <= c.operation;
						status_q <= ST_OK;
						shown_q <= '0;
						scan_q <= '0;
						case (c.operation)
							OP_ENQ: begin
								if (qfull) begin
									status_q <= ST_Q_FULL;
								end else begin
									shown_q <= new_e;
									ticket_q <= ticket_q + 16'd1;
									qfill_q <= qfill_q + Cw'(1);
								end
							end
							OP_DEQ: begin
								if (qempty) begin
									status_q <= ST_Q_EMPTY;
								end else begin
									shown_q <= qcells[0];
									qfill_q <= qfill_q - Cw'(1);
								end
							end
							OP_PROMOTE: status_q <= ST_NO_PRIO;
							OP_S2Q: begin
								if (sempty) status_q <= ST_S_EMPTY;
							end
							default: ;
						endcase
					end
				end
				FSM_PROMOTE: begin
					if (prio_hit) begin
						shown_q <= scan_e;
						status_q <= ST_OK;
					end else begin
						scan_q <= scan_q + Aw'(1);
					end
				end
				FSM_XFER: begin
					if (op_q == OP_Q2S) begin
						if (!qempty && !sfull) begin
							sfill_q <= sfill_q + Cw'(1);
							qfill_q <= qfill_q - Cw'(1);
						end else begin
							status_q <= qempty ? ST_OK : ST_PARTIAL;
						end
					end else begin
						if (!sempty && !qfull) begin
							qfill_q <= qfill_q + Cw'(1);
							sfill_q <= sfill_q - Cw'(1);
						end else begin
							status_q <= sempty ? ST_OK : ST_PARTIAL;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp_d = '{status: status_q, entry_tag: shown_q.tag, entry_age: shown_q.age,
		entry_ticket: shown_q.ticket, queue_count: 5'(qfill_q), stack_count: 5'(sfill_q)};
	assign rsp.data = rsp_d;

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) cmd.ready |-> !rsp.valid;
	endproperty
	a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		qfill_q <= Cw'(Depth) && sfill_q <= Cw'(Depth)) else $error("fill overflow");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while stalled");
endmodule

>>> sim/tb_priority_promoting_queue_with_stack.sv
// Self-checking testbench for priority_promoting_queue_with_stack.
// Depends on ppqs_pkg, ppqs_if and the block itself; a predictor built on SV queues
// works out the response to every command and a monitor compares each response.
module tb_priority_promoting_queue_with_stack;
	import ppqs_pkg::*;

	localparam int Depth = DefDepth;
	localparam int CycleLimit = 3000000;
	localparam int RandomItems = 1800;

	logic clk;
	logic arst_n;

	ppqs_if #(.payload_t(cmd_t))       cmd_ch ();
	ppqs_if #(.payload_t(logic [7:0])) cfg_ch ();
	ppqs_if #(.payload_t(rsp_t))       rsp_ch ();

	priority_promoting_queue_with_stack #(.Depth(Depth)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.cfg    (cfg_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Predictor state.
	entry_t      model_queue[$];
	entry_t      model_stack[$];
	logic [15:0] model_ticket;
	logic [7:0]  model_prio_age;

	rsp_t pending_rsp[$];
	int   errors;
	int   cycles;
	int   hold_cycles;
	int   rsp_stall;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic rsp_t predict_response(cmd_t c);
		rsp_t   r;
		entry_t e;
		int     k;
		r = '0;
		r.status = ST_OK;
		case (c.operation)
			OP_ENQ: begin
				if (model_queue.size() >= Depth) begin
					r.status = ST_Q_FULL;
				end else begin
					e.tag = c.patient_tag;
					e.age = c.age;
					e.ticket = model_ticket;
					model_ticket = model_ticket + 16'd1;
					model_queue.push_back(e);
					r.entry_tag = e.tag;
					r.entry_age = e.age;
					r.entry_ticket = e.ticket;
				end
			end
			OP_DEQ: begin
				if (model_queue.size() == 0) begin
					r.status = ST_Q_EMPTY;
				end else begin
					e = model_queue.pop_front();
					r.entry_tag = e.tag;
					r.entry_age = e.age;
					r.entry_ticket = e.ticket;
				end
			end
			OP_PROMOTE: begin
				r.status = ST_NO_PRIO;
				for (k = 0; k < model_queue.size(); k++) begin
					if (model_queue[k].age >= model_prio_age) begin
						e = model_queue[k];
						model_queue.delete(k);
						model_queue.push_front(e);
						r.status = ST_OK;
						r.entry_tag = e.tag;
						r.entry_age = e.age;
						r.entry_ticket = e.ticket;
						break;
					end
				end
			end
			OP_Q2S: begin
				while (model_queue.size() > 0 && model_stack.size() < Depth)
					model_stack.push_back(model_queue.pop_front());
				if (model_queue.size() > 0) r.status = ST_PARTIAL;
			end
			OP_S2Q: begin
				if (model_stack.size() == 0) begin
					r.status = ST_S_EMPTY;
				end else begin
					while (model_stack.size() > 0 && model_queue.size() < Depth)
						model_queue.push_back(model_stack.pop_back());
					if (model_stack.size() > 0) r.status = ST_PARTIAL;
				end
			end
			default: ;
		endcase
		r.queue_count = 5'(model_queue.size());
		r.stack_count = 5'(model_stack.size());
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, field, want, got);
		errors++;
	endtask

	// Sends one command after the given number of idle cycles.
	task automatic send_cmd(op_t op, logic [31:0] tag, logic [7:0] age, int gap);
		cmd_t c;
		c.operation = op;
		c.patient_tag = tag;
		c.age = age;
		if (gap > 0) begin
			@(negedge clk) cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_rsp.push_back(predict_response(c));
	endtask

	task automatic end_cmds();
		@(negedge clk) cmd_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		end_cmds();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_prio_age(logic [7:0] value);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		model_prio_age = value;
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] random_age();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		int i;
		send_cmd(OP_DEQ, '0, '0, 0);
		send_cmd(OP_PROMOTE, '0, '0, 0);
		send_cmd(OP_S2Q, '0, '0, 0);
		send_cmd(OP_Q2S, '0, '0, 0);
		send_cmd(op_t'(3'd5), 32'hFFFF_FFFF, 8'hFF, 0);
		send_cmd(op_t'(3'd6), '0, '0, 1);
		send_cmd(op_t'(3'd7), '0, '0, 0);
		send_cmd(OP_ENQ, 32'h0, 8'd0, 0);
		send_cmd(OP_ENQ, 32'hFFFF_FFFF, 8'd255, 0);
		send_cmd(OP_PROMOTE, '0, '0, 0);
		// The promoted entry is now the head, so a second promote finds it there.
		send_cmd(OP_PROMOTE, '0, '0, 0);
		for (i = 0; i < 15; i++) send_cmd(OP_ENQ, $urandom, 8'(i * 17), 0);
		send_cmd(OP_Q2S, '0, '0, 0);
		for (i = 0; i < 17; i++) send_cmd(OP_ENQ, $urandom, random_age(), 0);
		send_cmd(OP_Q2S, '0, '0, 0);
		send_cmd(OP_S2Q, '0, '0, 0);
		for (i = 0; i < 5; i++) send_cmd(OP_DEQ, '0, '0, 0);
		send_cmd(OP_S2Q, '0, '0, 0);
		while (model_queue.size() > 0) send_cmd(OP_DEQ, '0, '0, 0);
		while (model_stack.size() > 0) send_cmd(OP_S2Q, '0, '0, 0);
		while (model_queue.size() > 0) send_cmd(OP_DEQ, '0, '0, 0);
		wait_drained();
	endtask

	task automatic test_random(int n);
		int   i;
		int   r;
		op_t  op;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) op = OP_ENQ;
			else if (r < 65) op = OP_DEQ;
			else if (r < 80) op = OP_PROMOTE;
			else if (r < 88) op = OP_Q2S;
			else if (r < 96) op = OP_S2Q;
			else op = op_t'(3'($urandom_range(5, 7)));
			send_cmd(op, $urandom, random_age(), pick_gap());
		end
	endtask

	task automatic test_backpressure();
		int i;
		hold_cycles = 400;
		for (i = 0; i < 30; i++) send_cmd(OP_ENQ, $urandom, random_age(), 0);
		wait_drained();
		for (i = 0; i < 20; i++) send_cmd(OP_DEQ, '0, '0, 0);
		wait_drained();
	endtask

	// Receiver side: random stalls plus an optional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_ch.ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_stall--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end else if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				$display("unexpected response transaction at cycle %0d", cycles);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", 32'(want.status), 32'(got.status));
				if (got.entry_tag !== want.entry_tag)
					report_mismatch("entry_tag", want.entry_tag, got.entry_tag);
				if (got.entry_age !== want.entry_age)
					report_mismatch("entry_age", 32'(want.entry_age), 32'(got.entry_age));
				if (got.entry_ticket !== want.entry_ticket)
					report_mismatch("entry_ticket", 32'(want.entry_ticket),
						32'(got.entry_ticket));
				if (got.queue_count !== want.queue_count)
					report_mismatch("queue_count", 32'(want.queue_count),
						32'(got.queue_count));
				if (got.stack_count !== want.stack_count)
					report_mismatch("stack_count", 32'(want.stack_count),
						32'(got.stack_count));
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		rsp_stall = 0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		model_ticket = 16'd1;
		model_prio_age = DefPriorityAge;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(RandomItems / 5);
		write_prio_age(8'd0);
		test_random(RandomItems / 5);
		write_prio_age(8'd255);
		test_random(RandomItems / 5);
		test_backpressure();
		write_prio_age(8'($urandom));
		test_random(RandomItems / 5);
		write_prio_age(8'd70);
		test_random(RandomItems / 5);
		wait_drained();

		repeat (20) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

>>> priority_promoting_queue_with_stack.f
rtl/core/ppqs_pkg.sv
rtl/core/ppqs_if.sv
rtl/core/ppqs_cell.sv
rtl/core/ppqs_row.sv
rtl/core/priority_promoting_queue_with_stack.sv
sim/tb_priority_promoting_queue_with_stack.sv
